>>> hw/rtl/rdc_pkg.sv
// Shared types, constants and helper functions for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

    localparam int MaxDigits   = 32;
    localparam int DigitLimit  = (MaxDigits < 31) ? MaxDigits : 31;
    localparam int CountW      = $clog2(MaxDigits + 1);
    localparam int StackAw     = $clog2(MaxDigits);
    localparam int QueueDepth  = 2;
    localparam int QueuePtrW   = $clog2(QueueDepth);
    localparam int MagW        = 31;
    localparam int BaseW       = 4;
    localparam int RecipW      = 32;
    localparam int ProdW       = MagW + RecipW;

    localparam logic [BaseW-1:0] RadixReset    = 4'd10;
    localparam logic [BaseW-1:0] MinBase       = 4'd2;
    localparam logic [BaseW-1:0] MaxBase       = 4'd10;
    localparam logic [3:0]       MaxDigitValue = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_EMIT
    } state_t;

    // One positive value waiting for conversion, with the base captured on entry.
    typedef struct packed {
        logic [MagW-1:0]  value;
        logic [BaseW-1:0] base;
    } q_entry_t;

    typedef struct packed {
        state_t            state;
        logic [CountW-1:0] count;
    } back_stat_t;

    // Register codes outside 2..10 are folded onto the nearest legal base.
    function automatic logic [BaseW-1:0] eff_base(input logic [BaseW-1:0] r);
        logic [BaseW-1:0] b;
        case (r) inside
            [4'd0:4'd1]:   b = MinBase;
            [4'd11:4'd15]: b = MaxBase;
            default:       b = r;
        endcase
        return b;
    endfunction

    // floor(2^32 / base); the estimate it gives is the true quotient or one below.
    function automatic logic [RecipW-1:0] recip(input logic [BaseW-1:0] b);
        logic [RecipW-1:0] m;
        case (b)
            4'd2:    m = 32'h8000_0000;
            4'd3:    m = 32'h5555_5555;
            4'd4:    m = 32'h4000_0000;
            4'd5:    m = 32'h3333_3333;
            4'd6:    m = 32'h2AAA_AAAA;
            4'd7:    m = 32'h2492_4924;
            4'd8:    m = 32'h2000_0000;
            4'd9:    m = 32'h1C71_C71C;
            4'd10:   m = 32'h1999_9999;
            default: m = 32'h8000_0000;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/rdc_front.sv
// Front end: radix register, input beat acceptance and classification of values.
`timescale 1ns / 1ps

module rdc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            radix,
    input  logic                  q_full,
    output logic                  q_push,
    output rdc_pkg::q_entry_t     q_wdata
);

    logic [3:0] radix_reg;
    logic [3:0] radix_next;
    logic       accept;
    logic       positive;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    // Zero and negative values are accepted and dropped here; they produce no digits.
    assign positive  = !value[31] && (value != 32'd0);
    assign q_push    = accept && positive;

    assign q_wdata.value = value[rdc_pkg::MagW-1:0];
    assign q_wdata.base  = rdc_pkg::eff_base(radix_reg);

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_valid && cfg_ready)
        begin
            radix_next = radix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rdc_pkg::RadixReset;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

endmodule

>>> hw/rtl/rdc_queue.sv
// Small FIFO that decouples the front end from the conversion back end.
`timescale 1ns / 1ps

module rdc_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  rdc_pkg::q_entry_t                wdata,
    output logic                             full,
    input  logic                             pop,
    output logic                             valid,
    output rdc_pkg::q_entry_t                rdata,
    output logic [rdc_pkg::QueuePtrW:0]      level
);

    rdc_pkg::q_entry_t mem [rdc_pkg::QueueDepth];

    logic [rdc_pkg::QueuePtrW-1:0] wr_ptr_reg;
    logic [rdc_pkg::QueuePtrW-1:0] wr_ptr_next;
    logic [rdc_pkg::QueuePtrW-1:0] rd_ptr_reg;
    logic [rdc_pkg::QueuePtrW-1:0] rd_ptr_next;
    logic [rdc_pkg::QueuePtrW:0]   level_reg;
    logic [rdc_pkg::QueuePtrW:0]   level_next;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (level_reg == (rdc_pkg::QueuePtrW + 1)'(rdc_pkg::QueueDepth));
    assign valid   = (level_reg != '0);
    assign rdata   = mem[rd_ptr_reg];
    assign level   = level_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rdc_pkg::QueuePtrW'(rdc_pkg::QueueDepth - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rdc_pkg::QueuePtrW'(rdc_pkg::QueueDepth - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> hw/rtl/rdc_back.sv
// Back end: reciprocal-multiply digit extraction, digit stack and output register.
`timescale 1ns / 1ps

module rdc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  rdc_pkg::q_entry_t     q_rdata,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            digit,
    output logic                  last_digit,
    output rdc_pkg::back_stat_t   status
);

    localparam logic [rdc_pkg::CountW-1:0] CountLimit = rdc_pkg::CountW'(rdc_pkg::DigitLimit);
    localparam logic [rdc_pkg::CountW-1:0] CountOne   = rdc_pkg::CountW'(1);

    logic [3:0] stack [rdc_pkg::MaxDigits];

    rdc_pkg::state_t                state_reg;
    rdc_pkg::state_t                state_next;
    logic [rdc_pkg::CountW-1:0]     cnt_reg;
    logic [rdc_pkg::CountW-1:0]     cnt_next;
    logic                           ov_reg;
    logic                           ov_next;
    logic [rdc_pkg::MagW-1:0]       x_reg;
    logic [rdc_pkg::MagW-1:0]       x_next;
    logic [rdc_pkg::BaseW-1:0]      base_reg;
    logic [rdc_pkg::BaseW-1:0]      base_next;
    logic [rdc_pkg::MagW-1:0]       qest_reg;
    logic [rdc_pkg::MagW-1:0]       qest_next;
    logic [3:0]                     digit_reg;
    logic                           last_reg;
    logic                           last_next;

    logic [rdc_pkg::ProdW-1:0]      mul_full;
    logic [rdc_pkg::MagW+3:0]       back_prod;
    logic [rdc_pkg::MagW+3:0]       rem_wide;
    logic [4:0]                     rem;
    logic                           fix;
    logic [rdc_pkg::MagW-1:0]       q_fix;
    logic [4:0]                     d_wide;
    logic [3:0]                     d_fix;
    logic [rdc_pkg::CountW-1:0]     cnt_inc;
    logic [rdc_pkg::CountW-1:0]     cnt_dec;
    logic                           out_free;
    logic                           stack_we;
    logic                           stack_re;

    assign mul_full  = rdc_pkg::ProdW'(x_reg) * rdc_pkg::ProdW'(rdc_pkg::recip(base_reg));
    // The estimate is never above the true quotient, so the remainder is below twice the base.
    assign back_prod = (rdc_pkg::MagW + 4)'(qest_reg) * (rdc_pkg::MagW + 4)'(base_reg);
    assign rem_wide  = (rdc_pkg::MagW + 4)'(x_reg) - back_prod;
    assign rem       = rem_wide[4:0];
    assign fix       = (rem >= {1'b0, base_reg});
    assign q_fix     = fix ? qest_reg + 1'b1 : qest_reg;
    assign d_wide    = fix ? rem - {1'b0, base_reg} : rem;
    assign d_fix     = d_wide[3:0];
    assign cnt_inc   = cnt_reg + CountOne;
    assign cnt_dec   = cnt_reg - CountOne;
    assign out_free  = !ov_reg || !out_stall;

    assign out_valid    = ov_reg;
    assign digit        = digit_reg;
    assign last_digit   = last_reg;
    assign status.state = state_reg;
    assign status.count = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && out_stall;
        x_next     = x_reg;
        base_next  = base_reg;
        qest_next  = qest_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        stack_we   = 1'b0;
        stack_re   = 1'b0;
        case (state_reg)
            rdc_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    x_next     = q_rdata.value;
                    base_next  = q_rdata.base;
                    cnt_next   = '0;
                    state_next = rdc_pkg::ST_MUL;
                end
            end
            rdc_pkg::ST_MUL:
            begin
                qest_next  = mul_full[rdc_pkg::ProdW-1:rdc_pkg::RecipW];
                state_next = rdc_pkg::ST_FIX;
            end
            rdc_pkg::ST_FIX:
            begin
                stack_we = 1'b1;
                x_next   = q_fix;
                cnt_next = cnt_inc;
                if ((q_fix == '0) || (cnt_inc == CountLimit))
                begin
                    state_next = rdc_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = rdc_pkg::ST_MUL;
                end
            end
            rdc_pkg::ST_EMIT:
            begin
                // Digits leave in reverse order of discovery, most significant first.
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    stack_re   = 1'b1;
                    last_next  = (cnt_reg == CountOne);
                    cnt_next   = cnt_dec;
                    if (cnt_reg == CountOne)
                    begin
                        state_next = rdc_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        base_reg  <= base_next;
        qest_reg  <= qest_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack[cnt_reg[rdc_pkg::StackAw-1:0]] <= d_fix;
        end
        if (stack_re)
        begin
            digit_reg <= stack[cnt_dec[rdc_pkg::StackAw-1:0]];
        end
    end

endmodule

>>> hw/rtl/radix_digit_converter_core.sv
// Top level of the radix digit converter: front end, queue and back end.
`timescale 1ns / 1ps

// Each input beat carries a signed 32-bit value; a positive value is converted to the base
// in the radix register (codes below 2 act as base 2, codes above 10 as base 10) and its
// digits leave one per output beat, most significant first, with last_digit set on the
// final one. Zero and negative values are consumed and give no output. Each digit goes
// through the shared reciprocal multiplier and then the correction step; the stack is
// then read out one digit per cycle into the output register while the output is not
// stalled. A two-entry queue lets the input keep taking beats while a conversion runs,
// and the back end starts the next item while the last digit waits.
// Write the radix only while no conversion is pending.

module radix_digit_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  digit,
    output logic        last_digit,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  radix
);

    logic                          q_full;
    logic                          q_push;
    rdc_pkg::q_entry_t             q_wdata;
    logic                          q_pop;
    logic                          q_valid;
    rdc_pkg::q_entry_t             q_rdata;
    logic [rdc_pkg::QueuePtrW:0]   q_level;
    rdc_pkg::back_stat_t           back_stat;

    rdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .radix     (radix),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    rdc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata),
        .level (q_level)
    );

    rdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit      (digit),
        .last_digit (last_digit),
        .status     (back_stat)
    );

    // The read-out state always has at least one digit left on the stack.
    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.state == rdc_pkg::ST_EMIT) |-> (back_stat.count != '0))
        else $error("back end reading out an empty digit stack");

    // The stack is fully drained before the back end takes a new item.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.state == rdc_pkg::ST_IDLE) |-> (back_stat.count == '0))
        else $error("back end idle with digits left on the stack");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= (rdc_pkg::QueuePtrW + 1)'(rdc_pkg::QueueDepth))
        else $error("queue level beyond its depth");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit <= rdc_pkg::MaxDigitValue))
        else $error("digit outside 0 to 9");

endmodule
